// ===== hdl/lofu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lofu_pkg;

  localparam int MEM_BYTES      = 4096;
  localparam int INDEX_SPAN     = 512;
  localparam int REGISTER_COUNT = 16;

  localparam int AddrW    = $clog2(MEM_BYTES);
  localparam int IdxW     = $clog2(INDEX_SPAN);
  localparam int RegW     = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int NumBanks = 4;
  localparam int BankW    = 2;
  localparam int RowW     = AddrW - BankW;
  localparam int Rows     = MEM_BYTES / NumBanks;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    MODE_MEM_LOAD = 2'd0,
    MODE_REG_LOAD = 2'd1,
    MODE_EXEC     = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_AND = 2'd0,
    OP_OR  = 2'd1,
    OP_XOR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_REG      = 2'd1,
    KIND_DIRECT   = 2'd2,
    KIND_INDIRECT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_EXEC   = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_LOAD   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ITEM_EXEC,
    ITEM_MEM_LOAD,
    ITEM_REG_LOAD,
    ITEM_LOAD_SKIP,
    ITEM_REJECT
  } item_class_e;

  typedef struct packed {
    kind_e             kind;
    logic [31:0]       imm;
    logic [AddrW-1:0]  addr;
    logic [RegW-1:0]   ridx;
  } operand_t;

  typedef struct packed {
    item_class_e       cls;
    op_e               op;
    operand_t          opa;
    operand_t          opb;
    logic [RegW-1:0]   dest;
    logic [AddrW-1:0]  load_addr;
    logic [RegW-1:0]   load_reg;
    logic [31:0]       load_value;
  } item_t;

endpackage

`default_nettype wire

// ===== hdl/logic_op_operand_fetch_unit.sv =====
// logic operation unit with operand fetch for one emulated process
//
// input channel (in_valid_i / in_stall_o) takes load and execute items; an
// item is taken on a rising edge with in_valid_i high and in_stall_o low.
// output channel (out_valid_o / out_stall_i) gives one result item per input
// item, in order. results sit in an output register, so new items are taken
// while a finished result waits.
//
// an execute item fetches operand a and then operand b, since both source
// operands share the single read port of each byte-memory bank and of the
// register file; load and rejected items pass one per cycle when neither side
// stalls. a two-entry queue decouples the classifying front end from the fetch
// and execute stages.
//
// reset: the 4096-byte memory is cleared by a pass over its rows, one row of
// four banks per cycle, during which in_stall_o stays high. the register file
// and carry flag read as zero straight after reset.
// while out_stall_i is high the result holds and the pipeline fills up to the
// queue depth, then in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module logic_op_operand_fetch_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire        [1:0]  mode_i,
  input  wire        [1:0]  op_i,
  input  wire        [11:0] position_i,
  input  wire        [1:0]  kind_a_i,
  input  wire signed [31:0] arg_a_i,
  input  wire        [1:0]  kind_b_i,
  input  wire signed [31:0] arg_b_i,
  input  wire        [1:0]  kind_dest_i,
  input  wire        [7:0]  dest_reg_i,
  input  wire        [11:0] load_addr_i,
  input  wire signed [31:0] load_value_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic       [1:0]  status_o,
  output logic signed [31:0] result_value_o,
  output logic              carry_out_o,
  output logic signed [31:0] fetched_a_o,
  output logic signed [31:0] fetched_b_o
);

  lofu_pkg::item_t front_item;
  lofu_pkg::item_t head_item;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            clearing;
  logic            push;

  assign in_stall_o = q_full || clearing;
  assign push       = in_valid_i && !in_stall_o;

  lofu_front u_front (
    .mode_i       (mode_i),
    .op_i         (op_i),
    .position_i   (position_i),
    .kind_a_i     (kind_a_i),
    .arg_a_i      (arg_a_i),
    .kind_b_i     (kind_b_i),
    .arg_b_i      (arg_b_i),
    .kind_dest_i  (kind_dest_i),
    .dest_reg_i   (dest_reg_i),
    .load_addr_i  (load_addr_i),
    .load_value_i (load_value_i),
    .item_o       (front_item)
  );

  lofu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  lofu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (head_item),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .carry_out_o    (carry_out_o),
    .fetched_a_o    (fetched_a_o),
    .fetched_b_o    (fetched_b_o)
  );

endmodule

`default_nettype wire

// ===== hdl/lofu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lofu_front (
  input  wire        [1:0]  mode_i,
  input  wire        [1:0]  op_i,
  input  wire        [11:0] position_i,
  input  wire        [1:0]  kind_a_i,
  input  wire signed [31:0] arg_a_i,
  input  wire        [1:0]  kind_b_i,
  input  wire signed [31:0] arg_b_i,
  input  wire        [1:0]  kind_dest_i,
  input  wire        [7:0]  dest_reg_i,
  input  wire        [11:0] load_addr_i,
  input  wire signed [31:0] load_value_i,
  output lofu_pkg::item_t   item_o
);

  function automatic lofu_pkg::operand_t build_operand(input logic [1:0] kind,
      input logic signed [31:0] arg, input logic [11:0] pos);
    lofu_pkg::operand_t           o;
    logic [lofu_pkg::IdxW-1:0]    low;
    logic signed [lofu_pkg::IdxW:0] off;
    o.kind = lofu_pkg::kind_e'(kind);
    o.imm  = arg;
    low    = arg[lofu_pkg::IdxW-1:0];
    // truncating remainder: a negative argument with nonzero low bits gives low - span
    off    = {arg[31] && (low != '0), low};
    o.addr = lofu_pkg::AddrW'(lofu_pkg::AddrW'(pos) + lofu_pkg::AddrW'(off));
    o.ridx = lofu_pkg::RegW'(arg - 32'sd1);
    return o;
  endfunction

  function automatic logic reg_num_ok(input logic signed [31:0] n);
    return (n >= 32'sd1) && (n <= 32'(lofu_pkg::REGISTER_COUNT));
  endfunction

  logic op_ok;
  logic dest_ok;
  logic src_ok;
  logic exec_ok;

  assign op_ok   = (op_i == lofu_pkg::OP_AND) || (op_i == lofu_pkg::OP_OR) ||
                   (op_i == lofu_pkg::OP_XOR);
  assign dest_ok = (kind_dest_i == lofu_pkg::KIND_REG) && (32'(dest_reg_i) >= 32'd1) &&
                   (32'(dest_reg_i) <= 32'(lofu_pkg::REGISTER_COUNT));
  assign src_ok  = !((kind_a_i == lofu_pkg::KIND_REG) && !reg_num_ok(arg_a_i)) &&
                   !((kind_b_i == lofu_pkg::KIND_REG) && !reg_num_ok(arg_b_i));
  assign exec_ok = op_ok && dest_ok && src_ok;

  always_comb begin
    item_o            = '0;
    item_o.op         = lofu_pkg::op_e'(op_i);
    item_o.opa        = build_operand(kind_a_i, arg_a_i, position_i);
    item_o.opb        = build_operand(kind_b_i, arg_b_i, position_i);
    item_o.dest       = lofu_pkg::RegW'(dest_reg_i - 8'd1);
    item_o.load_addr  = lofu_pkg::AddrW'(load_addr_i);
    item_o.load_reg   = lofu_pkg::RegW'(load_addr_i);
    item_o.load_value = load_value_i;
    unique case (lofu_pkg::mode_e'(mode_i))
      lofu_pkg::MODE_MEM_LOAD: begin
        item_o.cls = lofu_pkg::ITEM_MEM_LOAD;
      end
      lofu_pkg::MODE_REG_LOAD: begin
        if (32'(load_addr_i) < 32'(lofu_pkg::REGISTER_COUNT)) begin
          item_o.cls = lofu_pkg::ITEM_REG_LOAD;
        end else begin
          item_o.cls = lofu_pkg::ITEM_LOAD_SKIP;
        end
      end
      lofu_pkg::MODE_EXEC: begin
        item_o.cls = exec_ok ? lofu_pkg::ITEM_EXEC : lofu_pkg::ITEM_REJECT;
      end
      default: begin
        item_o.cls = lofu_pkg::ITEM_REJECT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/lofu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lofu_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  var lofu_pkg::item_t item_i,
  input  wire              pop_i,
  output logic             full_o,
  output logic             valid_o,
  output lofu_pkg::item_t  item_o
);

  lofu_pkg::item_t               ent_q [lofu_pkg::QDepth];
  logic [lofu_pkg::QPtrW-1:0]    wr_ptr_q;
  logic [lofu_pkg::QPtrW-1:0]    rd_ptr_q;
  logic [lofu_pkg::QCntW-1:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= lofu_pkg::QPtrW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= lofu_pkg::QPtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= lofu_pkg::QCntW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= lofu_pkg::QCntW'(cnt_q - 1'b1);
      end
    end
  end

  assign full_o  = (cnt_q == lofu_pkg::QCntW'(lofu_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = ent_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < lofu_pkg::QCntW'(lofu_pkg::QDepth))
    else $error("item pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("item popped from an empty queue");

endmodule

`default_nettype wire

// ===== hdl/lofu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lofu_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  var lofu_pkg::item_t q_item_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic        [1:0]  status_o,
  output logic signed [31:0] result_value_o,
  output logic               carry_out_o,
  output logic signed [31:0] fetched_a_o,
  output logic signed [31:0] fetched_b_o
);

  function automatic logic [31:0] operand_value(input lofu_pkg::kind_e kind,
      input logic [31:0] imm, input logic [31:0] rf_word, input logic [31:0] mem_word);
    logic [31:0] v;
    case (kind)
      lofu_pkg::KIND_REG:      v = rf_word;
      lofu_pkg::KIND_DIRECT:   v = imm;
      lofu_pkg::KIND_INDIRECT: v = mem_word;
      default:                 v = '0;
    endcase
    return v;
  endfunction

  // control
  logic                         clr_busy_q;
  logic [lofu_pkg::RowW-1:0]    clr_row_q;
  logic                         ph_q;
  logic                         ex_valid_q;
  logic                         out_valid_q;
  logic                         carry_q;

  // payload
  lofu_pkg::item_t              ex_item_q;
  logic [31:0]                  ex_a_q;
  logic [lofu_pkg::BankW-1:0]   rot_q;
  logic [31:0]                  rf_rd_q;
  lofu_pkg::status_e            out_status_q;
  logic [31:0]                  out_result_q;
  logic                         out_carry_q;
  logic [31:0]                  out_a_q;
  logic [31:0]                  out_b_q;

  logic                         ex_done;
  logic                         rd_go;
  logic                         rd_move;
  lofu_pkg::operand_t           rd_opnd;
  logic [31:0]                  mem_word;
  logic [31:0]                  ex_b;
  logic [31:0]                  ex_res;
  logic                         ex_zero;

  logic                         rf_we;
  logic [lofu_pkg::RegW-1:0]    rf_waddr;
  logic [31:0]                  rf_wdata;
  logic [lofu_pkg::NumBanks-1:0] bk_we;
  logic [lofu_pkg::RowW-1:0]    bk_waddr;
  logic [7:0]                   bk_wdata;
  wire  [7:0]                   bank_rd [lofu_pkg::NumBanks];

  logic [31:0]                  rf_q [lofu_pkg::REGISTER_COUNT];
  logic [lofu_pkg::REGISTER_COUNT-1:0] rf_vld_q;

  assign ex_done = ex_valid_q && (!out_valid_q || !out_stall_i);
  // the fetch stage only reads while nothing older is left to write
  assign rd_go   = q_valid_i && !clr_busy_q && (ph_q || !ex_valid_q || ex_done);
  assign rd_move = rd_go && (ph_q || (q_item_i.cls != lofu_pkg::ITEM_EXEC));
  assign rd_opnd = ph_q ? q_item_i.opb : q_item_i.opa;

  assign q_pop_o    = rd_move;
  assign clearing_o = clr_busy_q;

  // byte memory in four banks, so a four-byte word touches each bank once
  for (genvar k = 0; k < lofu_pkg::NumBanks; k++) begin : g_bank
    logic [7:0]                mem_q [lofu_pkg::Rows];
    logic [7:0]                rdata_q;
    logic [lofu_pkg::RowW-1:0] rrow;

    assign rrow = lofu_pkg::RowW'(rd_opnd.addr[lofu_pkg::AddrW-1:lofu_pkg::BankW] +
                  lofu_pkg::RowW'(lofu_pkg::BankW'(k) < rd_opnd.addr[lofu_pkg::BankW-1:0]));

    always_ff @(posedge clk_i) begin
      if (bk_we[k]) begin
        mem_q[bk_waddr] <= bk_wdata;
      end
      if (rd_go) begin
        if (bk_we[k] && (bk_waddr == rrow)) begin
          rdata_q <= bk_wdata;
        end else begin
          rdata_q <= mem_q[rrow];
        end
      end
    end

    assign bank_rd[k] = rdata_q;
  end

  // big-endian word starting at the bank picked by the low address bits
  always_comb begin
    mem_word = '0;
    for (int i = 0; i < lofu_pkg::NumBanks; i++) begin
      mem_word[31-8*i -: 8] = bank_rd[lofu_pkg::BankW'(rot_q + lofu_pkg::BankW'(i))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
    if (rd_go) begin
      if (rf_we && (rf_waddr == rd_opnd.ridx)) begin
        rf_rd_q <= rf_wdata;
      end else if (rf_vld_q[rd_opnd.ridx]) begin
        rf_rd_q <= rf_q[rd_opnd.ridx];
      end else begin
        rf_rd_q <= '0;
      end
    end
  end

  assign ex_b = operand_value(ex_item_q.opb.kind, ex_item_q.opb.imm, rf_rd_q, mem_word);

  always_comb begin
    case (ex_item_q.op)
      lofu_pkg::OP_AND: ex_res = ex_a_q & ex_b;
      lofu_pkg::OP_OR:  ex_res = ex_a_q | ex_b;
      default:          ex_res = ex_a_q ^ ex_b;
    endcase
  end

  assign ex_zero = (ex_res == '0);

  // single write point for register file and memory, in item order
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = ex_item_q.dest;
    rf_wdata = ex_res;
    bk_we    = '0;
    bk_waddr = ex_item_q.load_addr[lofu_pkg::AddrW-1:lofu_pkg::BankW];
    bk_wdata = ex_item_q.load_value[7:0];
    if (clr_busy_q) begin
      bk_we    = '1;
      bk_waddr = clr_row_q;
      bk_wdata = '0;
    end else if (ex_done) begin
      case (ex_item_q.cls)
        lofu_pkg::ITEM_EXEC: begin
          rf_we = 1'b1;
        end
        lofu_pkg::ITEM_REG_LOAD: begin
          rf_we    = 1'b1;
          rf_waddr = ex_item_q.load_reg;
          rf_wdata = ex_item_q.load_value;
        end
        lofu_pkg::ITEM_MEM_LOAD: begin
          bk_we[ex_item_q.load_addr[lofu_pkg::BankW-1:0]] = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_row_q   <= '0;
      ph_q        <= 1'b0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      carry_q     <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_row_q <= lofu_pkg::RowW'(clr_row_q + 1'b1);
        if (clr_row_q == lofu_pkg::RowW'(lofu_pkg::Rows - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (rd_go) begin
        ph_q <= !rd_move;
      end
      if (rd_move) begin
        ex_valid_q <= 1'b1;
      end else if (ex_done) begin
        ex_valid_q <= 1'b0;
      end
      if (ex_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ex_done && (ex_item_q.cls == lofu_pkg::ITEM_EXEC)) begin
        carry_q <= ex_zero;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_go) begin
      rot_q <= rd_opnd.addr[lofu_pkg::BankW-1:0];
    end
    if (rd_move) begin
      ex_item_q <= q_item_i;
      // operand a was read in the previous cycle
      ex_a_q    <= operand_value(q_item_i.opa.kind, q_item_i.opa.imm, rf_rd_q, mem_word);
    end
    if (ex_done) begin
      if (ex_item_q.cls == lofu_pkg::ITEM_EXEC) begin
        out_status_q <= lofu_pkg::STATUS_EXEC;
        out_result_q <= ex_res;
        out_carry_q  <= ex_zero;
        out_a_q      <= ex_a_q;
        out_b_q      <= ex_b;
      end else begin
        out_status_q <= (ex_item_q.cls == lofu_pkg::ITEM_REJECT) ?
                        lofu_pkg::STATUS_REJECT : lofu_pkg::STATUS_LOAD;
        out_result_q <= '0;
        out_carry_q  <= carry_q;
        out_a_q      <= '0;
        out_b_q      <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_value_o = out_result_q;
  assign carry_out_o    = out_carry_q;
  assign fetched_a_o    = out_a_q;
  assign fetched_b_o    = out_b_q;

  a_ph_ex_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q |-> !ex_valid_q)
    else $error("second operand fetch while the execute stage is occupied");

  a_ph_head_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q |-> q_valid_i && (q_item_i.cls == lofu_pkg::ITEM_EXEC))
    else $error("queue head changed between the two operand fetches");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !rd_go && !ex_valid_q && !ph_q)
    else $error("item in flight during the memory clearing pass");

endmodule

`default_nettype wire
